[hw/rtl/dsjd_pkg.sv]
// Shared types and constants for the dual-server job dispatcher.
// No dependencies.
`timescale 1ns / 1ps
package dsjd_pkg;

    localparam logic [23:0] TIME_MAX  = 24'hFFFFFF;
    localparam logic [4:0]  LIMIT_CAP = 5'd4;
    localparam logic [2:0]  LIMIT_RST = 3'd3;

    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic EV_DONE  = 1'b0;
    localparam logic EV_ABORT = 1'b1;

    localparam logic [1:0] SRV_REJECT = 2'd0;

    typedef struct packed {
        logic accept;
        logic chk;
        logic pop_rd;
        logic pop_ev;
        logic flush;
        logic sel;
    } t_cmd;

    typedef struct packed {
        logic ended;
        logic q_empty;
        logic live;
    } t_sts;

endpackage

[hw/rtl/dual_server_job_dispatcher.sv]
// Top level of the dual-server job dispatcher.
// Depends on dsjd_pkg, dsjd_ctrl, dsjd_dp.
//
// Channel   Ports                                        Transfer
// item in   start, busy, i_kind, i_job_id, i_duration,   start && !busy
//           i_timeout
// result    o_valid, o_event_*, o_server, o_delay, o_last o_valid (one cycle)
// config    i_cfg_we, i_cfg_data                         i_cfg_we
//
// An arrival leaves busy low; a rejection shows the next cycle. A tick keeps
// busy high through a check state per server, a read and an event state per
// popped queue entry, a further read state when a queue runs empty after an end,
// and a flush state; events wait in a pending register to mark the last.
// Reset (synchronous, active low) sets time to 1 and empties servers/queues.
// Results cannot be stalled.
`timescale 1ns / 1ps
module dual_server_job_dispatcher
    import dsjd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [15:0]        i_job_id,
    input  logic [15:0]        i_duration,
    input  logic [23:0]        i_timeout,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    output logic               o_valid,
    output logic               o_event_kind,
    output logic [15:0]        o_event_job,
    output logic [1:0]         o_server,
    output logic [23:0]        o_event_time,
    output logic signed [24:0] o_delay,
    output logic               o_last
);

    t_cmd cmd;
    t_sts sts;

    dsjd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    dsjd_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_kind),
        .i_job_id     (i_job_id),
        .i_duration   (i_duration),
        .i_timeout    (i_timeout),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_event_kind (o_event_kind),
        .o_event_job  (o_event_job),
        .o_server     (o_server),
        .o_event_time (o_event_time),
        .o_delay      (o_delay),
        .o_last       (o_last)
    );

endmodule

[hw/rtl/dsjd_ctrl.sv]
// Sequencer for the dispatcher: walks tick processing per server.
// Depends on dsjd_pkg.
`timescale 1ns / 1ps
module dsjd_ctrl
    import dsjd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_kind,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_POPRD = 3'd2;
    localparam logic [2:0] S_POPEV = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_sel, n_sel;
    logic       w_acc;

    assign busy  = (r_state != S_IDLE);
    assign w_acc = start && !busy;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = w_acc;
                if (w_acc && i_kind == KIND_TICK) begin
                    n_state = S_CHK;
                    n_sel   = 1'b0;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.ended) begin
                    n_state = S_POPRD;
                end else if (!r_sel) begin
                    n_sel = 1'b1;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_POPRD: begin
                if (!i_sts.q_empty) begin
                    o_cmd.pop_rd = 1'b1;
                    n_state = S_POPEV;
                end else if (!r_sel) begin
                    n_state = S_CHK;
                    n_sel   = 1'b1;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_POPEV: begin
                o_cmd.pop_ev = 1'b1;
                if (!i_sts.live) begin
                    n_state = S_POPRD;
                end else if (!r_sel) begin
                    n_state = S_CHK;
                    n_sel   = 1'b1;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

[hw/rtl/dsjd_dp.sv]
// Datapath: time counter, server records, two job queues, event output.
// Depends on dsjd_pkg.
`timescale 1ns / 1ps
module dsjd_dp
    import dsjd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_kind,
    input  logic [15:0]        i_job_id,
    input  logic [15:0]        i_duration,
    input  logic [23:0]        i_timeout,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    output logic               o_valid,
    output logic               o_event_kind,
    output logic [15:0]        o_event_job,
    output logic [1:0]         o_server,
    output logic [23:0]        o_event_time,
    output logic signed [24:0] o_delay,
    output logic               o_last
);

    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(2 * QUEUE_DEPTH);

    logic [23:0]   r_now;
    logic [2:0]    r_lim;
    logic          r_sbusy  [2];
    logic [15:0]   r_sjob   [2];
    logic [23:0]   r_sarr   [2];
    logic [23:0]   r_sstart [2];
    logic [15:0]   r_sdur   [2];
    logic [23:0]   r_sdl    [2];
    logic [HW-1:0] r_head   [2];
    logic [CW-1:0] r_cnt    [2];

    logic [79:0]   mem [2*QUEUE_DEPTH];
    logic [79:0]   r_rd;

    logic          r_pv, r_pk;
    logic [15:0]   r_pj;
    logic [1:0]    r_ps;
    logic [23:0]   r_pt;
    logic [24:0]   r_pd;

    logic          r_ov, r_ok, r_ol;
    logic [15:0]   r_oj;
    logic [1:0]    r_os;
    logic [23:0]   r_ot;
    logic [24:0]   r_od;

    logic          sel;
    logic          w_done, w_dl;
    logic [15:0]   rd_id, rd_dur;
    logic [23:0]   rd_arr, rd_dl;
    logic          ev_push, ev_k;
    logic [15:0]   ev_j;
    logic [1:0]    ev_s;
    logic [23:0]   ev_t;
    logic [24:0]   ev_d;

    logic          arr_acc, a_load, a_sel, a_push, a_q, a_rej;
    logic [4:0]    lim5, c0_5, c1_5;
    logic [IW:0]   sum, slot;
    logic [IW-1:0] widx, ridx;
    logic [HW-1:0] head_nx;

    assign sel    = i_cmd.sel;
    assign w_done = ({1'b0, r_sstart[sel]} + {9'd0, r_sdur[sel]}) <= {1'b0, r_now};
    assign w_dl   = r_now >= r_sdl[sel];
    assign rd_id  = r_rd[79:64];
    assign rd_arr = r_rd[63:40];
    assign rd_dur = r_rd[39:24];
    assign rd_dl  = r_rd[23:0];

    assign o_sts.ended   = r_sbusy[sel] && (w_done || w_dl);
    assign o_sts.q_empty = (r_cnt[sel] == '0);
    assign o_sts.live    = !(r_now >= rd_dl);

    always_comb begin
        ev_push = 1'b0;
        ev_k    = EV_DONE;
        ev_j    = r_sjob[sel];
        ev_s    = {1'b0, sel} + 2'd1;
        ev_t    = r_now;
        ev_d    = {1'b0, r_sstart[sel]} - {1'b0, r_sarr[sel]};
        if (i_cmd.chk && o_sts.ended) begin
            ev_push = 1'b1;
            if (!w_done) begin
                ev_k = EV_ABORT;
                ev_t = r_sdl[sel];
                ev_d = {1'b0, r_sdl[sel]} - {1'b0, r_sarr[sel]};
            end
        end else if (i_cmd.pop_ev && !o_sts.live) begin
            ev_push = 1'b1;
            ev_k    = EV_ABORT;
            ev_j    = rd_id;
            ev_d    = {1'b0, r_now} - {1'b0, rd_arr};
        end
    end

    always_comb begin
        lim5 = {2'd0, r_lim};
        if (lim5 > LIMIT_CAP) lim5 = LIMIT_CAP;
        if (lim5 > 5'(QUEUE_DEPTH)) lim5 = 5'(QUEUE_DEPTH);
        c0_5 = 5'(r_cnt[0]);
        c1_5 = 5'(r_cnt[1]);
        arr_acc = i_cmd.accept && (i_kind == KIND_ARRIVE);
        a_load  = 1'b0;
        a_sel   = 1'b0;
        a_push  = 1'b0;
        a_rej   = 1'b0;
        a_q     = !(c0_5 <= c1_5);
        if (!r_sbusy[0]) begin
            a_load = arr_acc;
        end else if (!r_sbusy[1]) begin
            a_load = arr_acc;
            a_sel  = 1'b1;
        end else if (c0_5 < lim5 || c1_5 < lim5) begin
            a_push = arr_acc;
        end else begin
            a_rej = arr_acc;
        end
        sum  = (IW+1)'(r_head[a_q]) + (IW+1)'(r_cnt[a_q]);
        slot = (sum >= (IW+1)'(QUEUE_DEPTH)) ? sum - (IW+1)'(QUEUE_DEPTH) : sum;
        widx = a_q ? IW'(slot) + IW'(QUEUE_DEPTH) : IW'(slot);
        ridx = sel ? IW'(r_head[sel]) + IW'(QUEUE_DEPTH) : IW'(r_head[sel]);
        head_nx = (r_head[sel] == HW'(QUEUE_DEPTH - 1)) ? '0 : r_head[sel] + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (a_push) begin
            mem[widx] <= {i_job_id, r_now, i_duration, i_timeout};
        end
        if (i_cmd.pop_rd) begin
            r_rd <= mem[ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_sjob[a_sel]   <= i_job_id;
            r_sarr[a_sel]   <= r_now;
            r_sstart[a_sel] <= r_now;
            r_sdur[a_sel]   <= i_duration;
            r_sdl[a_sel]    <= i_timeout;
        end else if (i_cmd.pop_ev && o_sts.live) begin
            r_sjob[sel]   <= rd_id;
            r_sarr[sel]   <= rd_arr;
            r_sstart[sel] <= r_now;
            r_sdur[sel]   <= rd_dur;
            r_sdl[sel]    <= rd_dl;
        end
        if (ev_push) begin
            r_pk <= ev_k;
            r_pj <= ev_j;
            r_ps <= ev_s;
            r_pt <= ev_t;
            r_pd <= ev_d;
        end
        if (a_rej) begin
            r_ok <= EV_ABORT;
            r_oj <= i_job_id;
            r_os <= SRV_REJECT;
            r_ot <= r_now;
            r_od <= '0;
            r_ol <= 1'b1;
        end else begin
            r_ok <= r_pk;
            r_oj <= r_pj;
            r_os <= r_ps;
            r_ot <= r_pt;
            r_od <= r_pd;
            r_ol <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= 24'd1;
            r_lim   <= LIMIT_RST;
            r_sbusy <= '{default: 1'b0};
            r_head  <= '{default: '0};
            r_cnt   <= '{default: '0};
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) r_lim <= i_cfg_data;
            if (i_cmd.accept && i_kind == KIND_TICK && r_now != TIME_MAX) begin
                r_now <= r_now + 24'd1;
            end
            if (a_load) r_sbusy[a_sel] <= 1'b1;
            if (i_cmd.chk && o_sts.ended) r_sbusy[sel] <= 1'b0;
            if (a_push) r_cnt[a_q] <= r_cnt[a_q] + 1'b1;
            if (i_cmd.pop_ev) begin
                r_head[sel] <= head_nx;
                r_cnt[sel]  <= r_cnt[sel] - 1'b1;
                if (o_sts.live) r_sbusy[sel] <= 1'b1;
            end
            r_ov <= a_rej || ((ev_push || i_cmd.flush) && r_pv);
            if (ev_push) r_pv <= 1'b1;
            else if (i_cmd.flush) r_pv <= 1'b0;
        end
    end

    assign o_valid      = r_ov;
    assign o_event_kind = r_ok;
    assign o_event_job  = r_oj;
    assign o_server     = r_os;
    assign o_event_time = r_ot;
    assign o_delay      = r_od;
    assign o_last       = r_ol;

endmodule

[tb/sv/tb_dual_server_job_dispatcher.sv]
// Testbench for dual_server_job_dispatcher: directed table then random arrivals/ticks,
// every event checked against a behavioral model of both servers and queues.
// Depends on dsjd_pkg and the dispatcher RTL.
`timescale 1ns / 1ps
module tb_dual_server_job_dispatcher;
    import dsjd_pkg::*;

    localparam int QD = 4;

    typedef struct {
        logic        kind;
        logic [15:0] job;
        logic [1:0]  srv;
        logic [23:0] t;
        logic [24:0] dly;
        logic        last;
    } t_ev;

    typedef struct {
        logic        kind;
        logic [15:0] id;
        logic [15:0] dur;
        logic [23:0] tmo;
        logic        chk;
        int          n_exp;
        logic [15:0] e_job;
        logic [1:0]  e_srv;
        logic [23:0] e_t;
    } t_row;

    logic i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic i_kind = 0, i_cfg_we = 0;
    logic [15:0] i_job_id = 0, i_duration = 0;
    logic [23:0] i_timeout = 0;
    logic [2:0] i_cfg_data = 0;
    logic o_valid, o_event_kind, o_last;
    logic [15:0] o_event_job;
    logic [1:0] o_server;
    logic [23:0] o_event_time;
    logic signed [24:0] o_delay;

    dual_server_job_dispatcher uut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // model state
    logic [23:0] now_t;
    logic        s_busy[2];
    logic [15:0] s_job[2], s_dur[2];
    logic [23:0] s_arr[2], s_st[2], s_dl[2];
    logic [15:0] q_id[2][QD], q_dur[2][QD];
    logic [23:0] q_arr[2][QD], q_dl[2][QD];
    int q_hd[2], q_cnt[2];
    logic [2:0] qlim;

    t_ev pending_events[$];
    int errors = 0;

    function automatic logic [24:0] diff25(logic [23:0] a, logic [23:0] b);
        return 25'({1'b0, a} - {1'b0, b});
    endfunction

    task automatic add_event(logic k, logic [15:0] j, logic [1:0] s, logic [23:0] t,
                             logic [24:0] d);
        t_ev e;
        e.kind = k; e.job = j; e.srv = s; e.t = t; e.dly = d; e.last = 0;
        pending_events = {pending_events, e};
    endtask

    task automatic run_server(int s);
        logic ended;
        logic [1:0] sn;
        int h;
        ended = 0;
        sn = 2'(s + 1);
        if (!s_busy[s]) return;
        if ({8'd0, s_st[s]} + s_dur[s] <= now_t) begin
            add_event(EV_DONE, s_job[s], sn, now_t, diff25(s_st[s], s_arr[s]));
            ended = 1;
        end else if (now_t >= s_dl[s]) begin
            add_event(EV_ABORT, s_job[s], sn, s_dl[s], diff25(s_dl[s], s_arr[s]));
            ended = 1;
        end
        if (!ended) return;
        s_busy[s] = 0;
        while (q_cnt[s] > 0) begin
            h = q_hd[s];
            q_hd[s] = (h + 1) % QD;
            q_cnt[s]--;
            if (now_t >= q_dl[s][h]) begin
                add_event(EV_ABORT, q_id[s][h], sn, now_t, diff25(now_t, q_arr[s][h]));
            end else begin
                s_busy[s] = 1; s_job[s] = q_id[s][h]; s_arr[s] = q_arr[s][h];
                s_st[s] = now_t; s_dur[s] = q_dur[s][h]; s_dl[s] = q_dl[s][h];
                break;
            end
        end
    endtask

    // returns the number of events the item causes
    task automatic predict_dispatch(logic k, logic [15:0] id, logic [15:0] dur,
                                    logic [23:0] tmo, output int n);
        int base, lim, s, slot;
        base = pending_events.size();
        if (k == KIND_TICK) begin
            if (now_t != TIME_MAX) now_t++;
            run_server(0);
            run_server(1);
        end else begin
            lim = (qlim > LIMIT_CAP) ? int'(LIMIT_CAP) : int'(qlim);
            if (lim > QD) lim = QD;
            s = !s_busy[0] ? 0 : (!s_busy[1] ? 1 : -1);
            if (s >= 0) begin
                s_busy[s] = 1; s_job[s] = id; s_arr[s] = now_t; s_st[s] = now_t;
                s_dur[s] = dur; s_dl[s] = tmo;
            end else if (q_cnt[0] < lim || q_cnt[1] < lim) begin
                s = (q_cnt[0] <= q_cnt[1]) ? 0 : 1;
                slot = (q_hd[s] + q_cnt[s]) % QD;
                q_id[s][slot] = id; q_arr[s][slot] = now_t;
                q_dur[s][slot] = dur; q_dl[s][slot] = tmo;
                q_cnt[s]++;
            end else begin
                add_event(EV_ABORT, id, SRV_REJECT, now_t, 25'd0);
            end
        end
        n = pending_events.size() - base;
        if (n > 0) pending_events[$].last = 1;
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_ev e;
        if (i_rst_n && o_valid) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event job %h", $time, o_event_job);
                errors++;
            end else begin
                e = pending_events.pop_front();
                if ({o_event_kind, o_event_job, o_server, o_event_time, o_delay, o_last} !==
                    {e.kind, e.job, e.srv, e.t, e.dly, e.last}) begin
                    $display("%0t: expected k%b j%h s%0d t%h d%h l%b, got k%b j%h s%0d t%h d%h l%b",
                             $time, e.kind, e.job, e.srv, e.t, e.dly, e.last,
                             o_event_kind, o_event_job, o_server, o_event_time,
                             o_delay, o_last);
                    errors++;
                end
            end
        end
    end

    // start stays high across a zero gap so each time step drives it once
    task automatic send_item(logic k, logic [15:0] id, logic [15:0] dur, logic [23:0] tmo,
                             output int n);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 0;
            i_job_id <= 16'($urandom); i_duration <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1; i_kind <= k; i_job_id <= id; i_duration <= dur; i_timeout <= tmo;
        do @(posedge i_clk); while (busy);
        predict_dispatch(k, id, dur, tmo, n);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 0;
        while (pending_events.size() > 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [2:0] v);
        drain();
        i_cfg_we <= 1; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        qlim = v;
    endtask

    t_row dir_rows[$];

    function automatic t_row mk(logic k, logic [15:0] id, logic [15:0] dur, logic [23:0] tmo,
                                logic chk = 0, int ne = 0, logic [15:0] ej = 0,
                                logic [1:0] es = 0, logic [23:0] et = 0);
        t_row r;
        r.kind = k; r.id = id; r.dur = dur; r.tmo = tmo; r.chk = chk; r.n_exp = ne;
        r.e_job = ej; r.e_srv = es; r.e_t = et;
        return r;
    endfunction

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int n, phase, k, nres;
        logic [23:0] tmo;
        logic [15:0] dur;
        now_t = 1; qlim = LIMIT_RST;
        for (int s = 0; s < 2; s++) begin
            s_busy[s] = 0; s_job[s] = 0; s_dur[s] = 0; s_arr[s] = 0; s_st[s] = 0;
            s_dl[s] = 0; q_hd[s] = 0; q_cnt[s] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: fill servers and queues, reject, zero duration, passed deadline
        dir_rows = {dir_rows, mk(KIND_TICK, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1, 0)};
        dir_rows = {dir_rows, mk(KIND_ARRIVE, 16'h0000, 16'h0000, 24'hFFFFFF)};
        dir_rows = {dir_rows, mk(KIND_ARRIVE, 16'hFFFF, 16'hFFFF, 24'h000000)};
        for (int i = 0; i < 6; i++)
            dir_rows = {dir_rows, mk(KIND_ARRIVE, 16'(16'h100 + i), 16'(i), 24'(4 + i))};
        dir_rows = {dir_rows, mk(KIND_ARRIVE, 16'hBEEF, 16'h5, 24'h10, 1, 1, 16'hBEEF,
                                 SRV_REJECT, 24'd2)};
        for (int i = 0; i < 12; i++)
            dir_rows = {dir_rows, mk(KIND_TICK, 16'($urandom), 16'($urandom),
                                     24'($urandom))};
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].dur, dir_rows[i].tmo, n);
            if (dir_rows[i].chk && (n != dir_rows[i].n_exp || (n > 0 &&
                ({pending_events[$].job, pending_events[$].srv, pending_events[$].t} !==
                 {dir_rows[i].e_job, dir_rows[i].e_srv, dir_rows[i].e_t})))) begin
                $display("%0t: directed row %0d expected %0d events, model gives %0d",
                         $time, i, dir_rows[i].n_exp, n);
                errors++;
            end
        end

        // random phases across queue limits, extremes included
        nres = 0;
        for (phase = 0; phase < 8; phase++) begin
            write_limit(phase == 0 ? 3'd0 : phase == 1 ? 3'd7 : phase == 2 ? 3'd4 :
                        3'($urandom_range(0, 7)));
            for (k = 0; k < 50; k++) begin
                dur = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                case ($urandom_range(0, 3))
                    0: tmo = 24'($urandom);
                    1: tmo = now_t - 24'($urandom_range(0, 3));
                    default: tmo = now_t + 24'($urandom_range(0, 12));
                endcase
                send_item($urandom_range(0, 9) < 5, 16'($urandom), dur, tmo, n);
                nres += n;
            end
        end

        // time saturation: drive time to the max is too slow, so stop here
        drain();
        if (errors == 0 && pending_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[dual_server_job_dispatcher.f]
hw/rtl/dsjd_pkg.sv
hw/rtl/dsjd_ctrl.sv
hw/rtl/dsjd_dp.sv
hw/rtl/dual_server_job_dispatcher.sv
tb/sv/tb_dual_server_job_dispatcher.sv
